### hdl/assert_macros.svh
// Assertion macros used by the RTL of the magic-number generator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

### hdl/idmn_pkg.sv
// Package for the invariant-divisor magic-number generator.
// Field widths, default word size and the sequencer state type; no dependencies.
`default_nettype none

package idmn_pkg;

	// Fixed widths of the item fields
	localparam int DIV_W   = 31;
	localparam int MULT_W  = 33;
	localparam int SHIFT_W = 5;

	// Default word size of the signed division being replaced
	localparam int WORD_BITS_DEF = 32;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOG,
		ST_DIV_LO,
		ST_DIV_HI,
		ST_REDUCE,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

### hdl/invariant_divisor_magic_number.sv
// Magic multiplier and post-shift generator for signed division by a constant.
// Depends on idmn_pkg and assert_macros.svh.
//
//   channel   handshake            fields
//   input     start / busy         divisor
//   result    done (1-cycle pulse) multiplier, post_shift, invalid
//
// One shared 32-bit compare-subtract unit does both long divisions, one
// dividend bit per cycle over WORD_BITS+32 bits each, after a ceil(log2)
// count; up to 31 halving steps and the result cycle follow.
// A divisor below two skips straight to the result cycle, the next one.
// Reset returns the sequencer to idle; busy stays high until the done cycle ends.
`default_nettype none
`include "assert_macros.svh"

module invariant_divisor_magic_number #(
	parameter int WORD_BITS = idmn_pkg::WORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [idmn_pkg::DIV_W-1:0]    divisor,
	output logic                               done,
	output logic [idmn_pkg::MULT_W-1:0]        multiplier,
	output logic [idmn_pkg::SHIFT_W-1:0]       post_shift,
	output logic                               invalid
);

	localparam int DW = WORD_BITS + idmn_pkg::DIV_W + 1; // dividend bits
	localparam int IW = $clog2(DW);                      // dividend bit index
	localparam int QW = WORD_BITS + 2;                   // quotient bits
	localparam int RW = idmn_pkg::DIV_W;                 // remainder bits
	localparam logic [IW-1:0] IDX_TOP = IW'(DW - 1);

	idmn_pkg::state_t state_q, state_nxt;

	logic [RW-1:0]                   d_q;
	logic [RW-1:0]                   v_q;
	logic [idmn_pkg::SHIFT_W-1:0]    l_q;
	logic [IW-1:0]                   idx_q;
	logic [RW-1:0]                   rem_q;
	logic [QW-1:0]                   q_q;
	logic [QW-1:0]                   low_q;
	logic                            inv_q;

	logic          accept;
	logic          bit_in;
	logic [RW:0]   trial;
	logic [RW:0]   diff;
	logic          ge;
	logic [RW-1:0] rem_nxt;
	logic          idx_zero;
	logic          reduce_go;

	assign accept = start && !busy;

	// Dividend is 2^(W+l), plus 2^(l+1) for the high value: only two bits set
	assign bit_in = (idx_q == (IW'(WORD_BITS) + IW'(l_q)))
		|| ((state_q == idmn_pkg::ST_DIV_HI) && (idx_q == (IW'(l_q) + IW'(1))));

	// Shared compare-subtract unit of the restoring divider
	assign trial   = {rem_q, bit_in};
	assign diff    = trial - {1'b0, d_q};
	assign ge      = trial >= {1'b0, d_q};
	assign rem_nxt = ge ? diff[RW-1:0] : trial[RW-1:0];

	assign idx_zero  = (idx_q == '0);
	assign reduce_go = ((low_q >> 1) < (q_q >> 1)) && (l_q != '0);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			idmn_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = (divisor < RW'(2)) ? idmn_pkg::ST_DONE : idmn_pkg::ST_LOG;
				end
			end
			idmn_pkg::ST_LOG: begin
				if (v_q == '0) state_nxt = idmn_pkg::ST_DIV_LO;
			end
			idmn_pkg::ST_DIV_LO: begin
				if (idx_zero) state_nxt = idmn_pkg::ST_DIV_HI;
			end
			idmn_pkg::ST_DIV_HI: begin
				if (idx_zero) state_nxt = idmn_pkg::ST_REDUCE;
			end
			idmn_pkg::ST_REDUCE: begin
				if (!reduce_go) state_nxt = idmn_pkg::ST_DONE;
			end
			idmn_pkg::ST_DONE: begin
				state_nxt = idmn_pkg::ST_IDLE;
			end
			default: state_nxt = idmn_pkg::ST_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		busy = (state_q != idmn_pkg::ST_IDLE);
		done = (state_q == idmn_pkg::ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idmn_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			idmn_pkg::ST_IDLE: begin
				if (accept) begin
					d_q   <= divisor;
					v_q   <= divisor - RW'(1);
					l_q   <= '0;
					q_q   <= '0;
					inv_q <= (divisor < RW'(2));
				end
			end
			// ceil(log2 d) = bit length of d-1
			idmn_pkg::ST_LOG: begin
				if (v_q != '0) begin
					v_q <= v_q >> 1;
					l_q <= l_q + idmn_pkg::SHIFT_W'(1);
				end else begin
					idx_q <= IDX_TOP;
					rem_q <= '0;
					q_q   <= '0;
				end
			end
			idmn_pkg::ST_DIV_LO: begin
				if (idx_zero) begin
					low_q <= {q_q[QW-2:0], ge};
					idx_q <= IDX_TOP;
					rem_q <= '0;
					q_q   <= '0;
				end else begin
					idx_q <= idx_q - IW'(1);
					rem_q <= rem_nxt;
					q_q   <= {q_q[QW-2:0], ge};
				end
			end
			idmn_pkg::ST_DIV_HI: begin
				idx_q <= idx_q - IW'(1);
				rem_q <= rem_nxt;
				q_q   <= {q_q[QW-2:0], ge};
			end
			// Halve both bounds while their halves still differ and the shift is nonzero
			idmn_pkg::ST_REDUCE: begin
				if (reduce_go) begin
					low_q <= low_q >> 1;
					q_q   <= q_q >> 1;
					l_q   <= l_q - idmn_pkg::SHIFT_W'(1);
				end
			end
			idmn_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Result fields, shown with done
	assign multiplier = idmn_pkg::MULT_W'(q_q);
	assign post_shift = l_q;
	assign invalid    = inv_q;

	// Checks
	`ASSERT_NEXT(a_done_then_idle, clk, arst_n, done, !busy)
	`ASSERT_NEXT(a_accept_then_busy, clk, arst_n, accept, busy && !done || done)
	`ASSERT_IMPLIES(a_invalid_zero, clk, arst_n, done && invalid, ({multiplier, post_shift} == '0))
	`ASSERT_NEXT(a_small_fast, clk, arst_n, accept && (divisor < RW'(2)), done && invalid)

endmodule

`default_nettype wire
